// ===== sv/rws_pkg.sv =====
// Package for the roulette wheel selector: field widths, request kinds,
// register map, parameter defaults and controller/datapath structs.
// No dependencies.
package rws_pkg;

	localparam int MAX_ENTRIES_DEF  = 256;
	localparam int FITNESS_BITS_DEF = 16;
	localparam int RANDOM_BITS_DEF  = 16;

	localparam int KIND_W = 2;
	localparam int IDX_W  = 8;
	localparam int FIT_W  = 16;
	localparam int RND_W  = 16;
	localparam int PCNT_W = 9;

	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 3;
	localparam int REG_IDX_W = 1;

	localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SELECT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_WITHOUT_REPL = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_POP_COUNT    = 1'd1;

	localparam logic [PCNT_W-1:0] POP_COUNT_RESET = 9'd256;

	typedef struct packed {
		logic wr_entry;
		logic r_load;
		logic addr_clr;
		logic rd_en;
		logic sum_clr;
		logic sum_acc;
		logic mul_lo;
		logic mul_hi;
		logic mul_add;
		logic prefix_clr;
		logic scan;
		logic mark_clr;
		logic res_miss;
		logic out_load;
	} rws_cmd_t;

	typedef struct packed {
		logic addr_end;
		logic addr_last;
		logic total_zero;
		logic dirty;
		logic hit;
	} rws_stat_t;

endpackage

// ===== sv/rws_req_if.sv =====
// Request channel of the roulette wheel selector: valid/ready plus payload.
// Depends on rws_pkg.
interface rws_req_if;
	logic                       valid;
	logic                       ready;
	logic [rws_pkg::KIND_W-1:0] kind;
	logic [rws_pkg::IDX_W-1:0]  entry_index;
	logic [rws_pkg::FIT_W-1:0]  fitness_value;
	logic [rws_pkg::RND_W-1:0]  random_fraction;

	modport source (
		output valid, kind, entry_index, fitness_value, random_fraction,
		input  ready
	);
	modport sink (
		input  valid, kind, entry_index, fitness_value, random_fraction,
		output ready
	);
endinterface

// ===== sv/rws_rsp_if.sv =====
// Result channel of the roulette wheel selector: valid/ready plus payload.
// Depends on rws_pkg.
interface rws_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [rws_pkg::IDX_W-1:0] chosen_index;
	logic                      found;

	modport source (
		output valid, chosen_index, found,
		input  ready
	);
	modport sink (
		input  valid, chosen_index, found,
		output ready
	);
endinterface

// ===== sv/roulette_wheel_selector.sv =====
// Roulette wheel selector, top level: request/result channels, APB register
// port, controller and datapath. Depends on rws_pkg, rws_req_if, rws_rsp_if,
// rws_ctrl and rws_dp.
//
// Requests arrive on req (valid/ready). A write request loads one fitness
// entry. A clear request drops all selection marks in a sweep of the mark
// memory. A select request returns one result on rsp: the first entry whose
// prefix sum exceeds fraction times total, or found low on a miss.
// When a write or a population change has left the total to be re-summed,
// a select first walks the single-port fitness memory, one entry a cycle,
// to re-sum it; it then forms the threshold and scans the same memory, one
// entry a cycle, until a hit or the end of the wheel.
// Results sit in an output register: new requests are taken while one waits,
// and a select that finishes while rsp is stalled holds until it is taken.
// After reset the block sweeps the mark memory with req.ready low; registers
// reset to repeats allowed and a wheel of 256.
// Registers: byte 0 without_replacement, byte 4 population_count. Write
// them only while idle.
module roulette_wheel_selector #(
	parameter int MAX_ENTRIES  = rws_pkg::MAX_ENTRIES_DEF,
	parameter int FITNESS_BITS = rws_pkg::FITNESS_BITS_DEF,
	parameter int RANDOM_BITS  = rws_pkg::RANDOM_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	rws_req_if.sink                     req,
	rws_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rws_pkg::ADDR_W-1:0]  paddr,
	input  logic [rws_pkg::DATA_W-1:0]  pwdata,
	output logic [rws_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import rws_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	logic                  without_repl_q;
	logic [PCNT_W-1:0]     pop_count_q;
	logic [CW-1:0]         wheel_size;
	logic [REG_IDX_W-1:0]  reg_idx;
	logic                  reg_wr;
	rws_cmd_t              cmd;
	rws_stat_t             stat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			without_repl_q <= 1'b0;
			pop_count_q    <= POP_COUNT_RESET;
		end else if (reg_wr) begin
			case (reg_idx)
				REG_WITHOUT_REPL: without_repl_q <= pwdata[0];
				REG_POP_COUNT:    pop_count_q    <= pwdata[PCNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WITHOUT_REPL: prdata = DATA_W'(without_repl_q);
			REG_POP_COUNT:    prdata = DATA_W'(pop_count_q);
			default:          prdata = '0;
		endcase
	end

	assign wheel_size = (32'(pop_count_q) > MAX_ENTRIES) ? CW'(MAX_ENTRIES)
	                                                     : CW'(pop_count_q);

	rws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.kind      (req.kind),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	rws_dp #(
		.MAX_ENTRIES  (MAX_ENTRIES),
		.FITNESS_BITS (FITNESS_BITS),
		.RANDOM_BITS  (RANDOM_BITS),
		.CW           (CW)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.stat                (stat),
		.entry_index         (req.entry_index),
		.fitness_value       (req.fitness_value),
		.random_fraction     (req.random_fraction),
		.without_replacement (without_repl_q),
		.wheel_size          (wheel_size),
		.chosen_index        (rsp.chosen_index),
		.found               (rsp.found)
	);

endmodule

// ===== sv/rws_dp.sv =====
// Datapath of the roulette wheel selector: fitness and mark memories, total,
// threshold multiply, prefix scan and result registers.
// Depends on rws_pkg; driven by rws_ctrl through rws_cmd_t.
module rws_dp #(
	parameter int MAX_ENTRIES  = rws_pkg::MAX_ENTRIES_DEF,
	parameter int FITNESS_BITS = rws_pkg::FITNESS_BITS_DEF,
	parameter int RANDOM_BITS  = rws_pkg::RANDOM_BITS_DEF,
	parameter int CW           = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rws_pkg::rws_cmd_t         cmd,
	output rws_pkg::rws_stat_t        stat,
	input  logic [rws_pkg::IDX_W-1:0] entry_index,
	input  logic [rws_pkg::FIT_W-1:0] fitness_value,
	input  logic [rws_pkg::RND_W-1:0] random_fraction,
	input  logic                      without_replacement,
	input  logic [CW-1:0]             wheel_size,
	output logic [rws_pkg::IDX_W-1:0] chosen_index,
	output logic                      found
);
	import rws_pkg::*;

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int TW = FITNESS_BITS + $clog2(MAX_ENTRIES);
	localparam int HW = (TW + 1) / 2;
	localparam int PW = RANDOM_BITS + HW;
	localparam int XW = TW + RANDOM_BITS;

	logic [FITNESS_BITS-1:0] fit_mem [MAX_ENTRIES];
	logic                    mark_mem [MAX_ENTRIES];

	logic [CW-1:0]           addr_q;
	logic                    rd_valid_s1;
	logic [IW-1:0]           idx_s1;
	logic [FITNESS_BITS-1:0] fit_rd_s1;
	logic                    mark_rd_s1;
	logic [TW-1:0]           total_q;
	logic [CW-1:0]           n_sum_q;
	logic                    dirty_q;
	logic [RANDOM_BITS-1:0]  r_q;
	logic [PW-1:0]           prod_q;
	logic [XW-1:0]           thr_q;
	logic [TW-1:0]           prefix_q;
	logic [TW-1:0]           prefix_nx;
	logic                    cond;
	logic [IDX_W-1:0]        pend_idx_q;
	logic                    pend_found_q;
	logic [IDX_W-1:0]        chosen_q;
	logic                    found_q;
	logic                    wr_ok;
	logic                    mark_we;
	logic [IW-1:0]           mark_wa;
	logic [HW-1:0]           mul_b;

	assign wr_ok     = 32'(entry_index) < MAX_ENTRIES;
	assign prefix_nx = prefix_q + TW'(fit_rd_s1);
	assign cond      = ({prefix_nx, {RANDOM_BITS{1'b0}}} > thr_q)
	                   && !(without_replacement && mark_rd_s1);

	assign stat.addr_end   = addr_q == wheel_size;
	assign stat.addr_last  = addr_q == CW'(MAX_ENTRIES - 1);
	assign stat.total_zero = total_q == '0;
	assign stat.dirty      = dirty_q || (n_sum_q != wheel_size);
	assign stat.hit        = rd_valid_s1 && cond;

	assign mark_we = cmd.mark_clr || (cmd.scan && stat.hit && without_replacement);
	assign mark_wa = cmd.mark_clr ? addr_q[IW-1:0] : idx_s1;
	assign mul_b   = cmd.mul_lo ? total_q[HW-1:0] : HW'(total_q[TW-1:HW]);

	always_ff @(posedge clk) begin
		if (cmd.wr_entry && wr_ok) begin
			fit_mem[IW'(entry_index)] <= FITNESS_BITS'(fitness_value);
		end
		if (cmd.rd_en) begin
			fit_rd_s1 <= fit_mem[addr_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[mark_wa] <= !cmd.mark_clr;
		end
		if (cmd.rd_en) begin
			mark_rd_s1 <= mark_mem[addr_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			rd_valid_s1 <= 1'b0;
			dirty_q     <= 1'b1;
			total_q     <= '0;
		end else begin
			rd_valid_s1 <= cmd.rd_en;
			if (cmd.addr_clr) begin
				addr_q <= '0;
			end else if (cmd.rd_en || cmd.mark_clr) begin
				addr_q <= addr_q + 1'b1;
			end
			if (cmd.wr_entry) begin
				dirty_q <= 1'b1;
			end else if (cmd.sum_clr) begin
				dirty_q <= 1'b0;
			end
			if (cmd.sum_clr) begin
				total_q <= '0;
			end else if (cmd.sum_acc && rd_valid_s1) begin
				total_q <= total_q + TW'(fit_rd_s1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			idx_s1 <= addr_q[IW-1:0];
		end
		if (cmd.sum_clr) begin
			n_sum_q <= wheel_size;
		end
		if (cmd.r_load) begin
			r_q <= RANDOM_BITS'(random_fraction);
		end
		if (cmd.mul_lo || cmd.mul_hi) begin
			prod_q <= PW'(r_q) * PW'(mul_b);
		end
		if (cmd.mul_hi) begin
			thr_q <= XW'(prod_q);
		end else if (cmd.mul_add) begin
			thr_q <= thr_q + (XW'(prod_q) << HW);
		end
		if (cmd.prefix_clr) begin
			prefix_q <= '0;
		end else if (cmd.scan && rd_valid_s1) begin
			prefix_q <= prefix_nx;
		end
		if (cmd.res_miss) begin
			pend_idx_q   <= '0;
			pend_found_q <= 1'b0;
		end else if (cmd.scan && stat.hit) begin
			pend_idx_q   <= IDX_W'(idx_s1);
			pend_found_q <= 1'b1;
		end
		if (cmd.out_load) begin
			chosen_q <= pend_idx_q;
			found_q  <= pend_found_q;
		end
	end

	assign chosen_index = chosen_q;
	assign found        = found_q;

endmodule

// ===== sv/rws_ctrl.sv =====
// Controller of the roulette wheel selector: sequences writes, mark clears,
// total recompute, threshold multiply, prefix scan and result hand-off.
// Depends on rws_pkg; commands rws_dp through rws_cmd_t.
module rws_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic [rws_pkg::KIND_W-1:0] kind,
	output logic                       out_valid,
	input  logic                       out_ready,
	output rws_pkg::rws_cmd_t          cmd,
	input  rws_pkg::rws_stat_t         stat
);
	import rws_pkg::*;

	localparam logic [3:0] ST_INIT = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_CLR  = 4'd2;
	localparam logic [3:0] ST_SUM  = 4'd3;
	localparam logic [3:0] ST_MUL0 = 4'd4;
	localparam logic [3:0] ST_MUL1 = 4'd5;
	localparam logic [3:0] ST_MUL2 = 4'd6;
	localparam logic [3:0] ST_SCAN = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nx;
	logic       out_valid_q;
	logic       accept;

	assign req_ready = state_q == ST_IDLE;
	assign accept    = req_valid && req_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			ST_INIT, ST_CLR: begin
				cmd.mark_clr = 1'b1;
				if (stat.addr_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (kind)
						KIND_WRITE: begin
							cmd.wr_entry = 1'b1;
						end
						KIND_SELECT: begin
							cmd.r_load   = 1'b1;
							cmd.addr_clr = 1'b1;
							cmd.sum_clr  = stat.dirty;
							state_nx     = stat.dirty ? ST_SUM : ST_MUL0;
						end
						KIND_CLEAR: begin
							cmd.addr_clr = 1'b1;
							state_nx     = ST_CLR;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SUM: begin
				cmd.sum_acc = 1'b1;
				cmd.rd_en   = !stat.addr_end;
				if (stat.addr_end) begin
					state_nx = ST_MUL0;
				end
			end
			ST_MUL0: begin
				if (stat.total_zero) begin
					cmd.res_miss = 1'b1;
					state_nx     = ST_OUT;
				end else begin
					cmd.mul_lo = 1'b1;
					state_nx   = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul_hi = 1'b1;
				state_nx   = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul_add    = 1'b1;
				cmd.addr_clr   = 1'b1;
				cmd.prefix_clr = 1'b1;
				state_nx       = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan  = 1'b1;
				cmd.rd_en = !stat.addr_end && !stat.hit;
				if (stat.hit) begin
					state_nx = ST_OUT;
				end else if (stat.addr_end) begin
					cmd.res_miss = 1'b1;
					state_nx     = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sim/rws_pick_checker.sv =====
`timescale 1ns / 100ps
// Pick checker for the roulette wheel selector: mirrors the fitness table, marks and
// registers from observed requests and register writes, predicts every pick and
// compares it with the result channel. Depends on rws_pkg, rws_req_if, rws_rsp_if.
module rws_pick_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	rws_req_if                         req,
	rws_rsp_if                         rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rws_pkg::ADDR_W-1:0] paddr,
	input  logic [rws_pkg::DATA_W-1:0] pwdata,
	input  logic                       pready,
	output int                         fail_count,
	output int                         pending_picks
);
	import rws_pkg::*;

	localparam int ENTRIES = MAX_ENTRIES_DEF;
	localparam int TOTAL_W = FIT_W + IDX_W;
	localparam int PROD_W  = RND_W + TOTAL_W;

	typedef struct packed {
		logic [IDX_W-1:0] chosen;
		logic             found;
	} pick_t;

	logic [FIT_W-1:0]   fit_tab [ENTRIES];
	logic               taken [ENTRIES];
	logic [TOTAL_W-1:0] wheel_total;
	logic               wo_repl;
	logic [PCNT_W-1:0]  pop_cnt;
	pick_t              expected_picks [$];

	function automatic int wheel_len();
		return (pop_cnt > ENTRIES) ? ENTRIES : int'(pop_cnt);
	endfunction

	task automatic resum_wheel_total();
		logic [TOTAL_W-1:0] sum;
		int                 i;
		sum = '0;
		for (i = 0; i < wheel_len(); i++)
			sum += TOTAL_W'(fit_tab[i]);
		wheel_total = sum;
	endtask

	task automatic predict_pick(input logic [RND_W-1:0] frac, output pick_t res);
		logic [TOTAL_W-1:0] prefix;
		logic [PROD_W-1:0]  scaled;
		int                 i;
		res = '0;
		prefix = '0;
		scaled = PROD_W'(frac) * PROD_W'(wheel_total);
		if (wheel_total != '0) begin
			for (i = 0; i < wheel_len(); i++) begin
				prefix += TOTAL_W'(fit_tab[i]);
				if (scaled < {prefix, {RND_W{1'b0}}} && !(wo_repl && taken[i])) begin
					res.chosen = IDX_W'(i);
					res.found = 1'b1;
					if (wo_repl)
						taken[i] = 1'b1;
					break;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pick_t got;
		pick_t want;
		if (!arst_n) begin
			foreach (fit_tab[i]) begin
				fit_tab[i] = '0;
				taken[i] = 1'b0;
			end
			wheel_total = '0;
			wo_repl = 1'b0;
			pop_cnt = POP_COUNT_RESET;
			expected_picks.delete();
			pending_picks = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.chosen = rsp.chosen_index;
				got.found = rsp.found;
				if (expected_picks.size() == 0) begin
					$error("result with no select waiting: chosen_index %0d, found %0d",
						got.chosen, got.found);
					fail_count++;
				end else begin
					want = expected_picks.pop_front();
					if (got.found !== want.found) begin
						$error("found: expected %0d, actual %0d", want.found, got.found);
						fail_count++;
					end
					if (got.chosen !== want.chosen) begin
						$error("chosen_index: expected %0d, actual %0d", want.chosen, got.chosen);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready) begin
				case (req.kind)
					KIND_WRITE: begin
						fit_tab[req.entry_index] = req.fitness_value;
						resum_wheel_total();
					end
					KIND_SELECT: begin
						predict_pick(req.random_fraction, want);
						expected_picks = {expected_picks, want};
					end
					KIND_CLEAR: begin
						foreach (taken[i])
							taken[i] = 1'b0;
					end
					default: ;
				endcase
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_WITHOUT_REPL: wo_repl = pwdata[0];
					REG_POP_COUNT: begin
						pop_cnt = pwdata[PCNT_W-1:0];
						resum_wheel_total();
					end
					default: ;
				endcase
			end
			pending_picks = expected_picks.size();
		end
	end

endmodule

// ===== sim/roulette_wheel_selector_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the roulette wheel selector: clock, reset, request and register
// stimulus, result back-pressure and the verdict. Depends on rws_pkg, rws_req_if,
// rws_rsp_if, roulette_wheel_selector and rws_pick_checker.
module roulette_wheel_selector_tb;
	import rws_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int CYCLE_LIMIT  = 5_000_000;
	localparam int DRAIN_CYCLES = 600;
	localparam int LONG_HOLD    = 3000;
	localparam int PHASES       = 10;
	localparam int HOLD_PHASE   = 6;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	localparam int PH_WO    [PHASES] = '{0, 1, 1, 0, 0, 1, 1, 0, 1, 0};
	localparam int PH_POP   [PHASES] = '{256, 16, 2, 1, 0, 511, 8, 37, 255, 5};
	localparam int PH_ITEMS [PHASES] = '{120, 210, 80, 50, 30, 120, 260, 210, 120, 270};

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  idx;
		logic [FIT_W-1:0]  fit;
		logic [RND_W-1:0]  frac;
	} req_item_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	int                fail_count;
	int                pending_picks;
	int                send_idle;
	int                recv_idle;
	int                cycles;
	bit                hold_rsp;

	rws_req_if req_ch ();
	rws_rsp_if rsp_ch ();

	roulette_wheel_selector dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	rws_pick_checker pick_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.fail_count    (fail_count),
		.pending_picks (pending_picks)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic req_item_t make_req(input logic [KIND_W-1:0] kind,
		input logic [IDX_W-1:0] idx, input logic [FIT_W-1:0] fit,
		input logic [RND_W-1:0] frac);
		req_item_t it;
		it.kind = kind;
		it.idx = idx;
		it.fit = fit;
		it.frac = frac;
		return it;
	endfunction

	function automatic logic [FIT_W-1:0] rand_fitness();
		int roll;
		roll = $urandom_range(99);
		if (roll < 15)
			return '0;
		if (roll < 30)
			return FIT_W'($urandom_range(15, 1));
		if (roll < 40)
			return '1;
		return FIT_W'($urandom);
	endfunction

	function automatic req_item_t rand_req(input int wheel);
		req_item_t it;
		int        roll;
		it = make_req(KIND_SELECT, IDX_W'($urandom), FIT_W'($urandom), RND_W'($urandom));
		roll = $urandom_range(99);
		if (roll < 62) begin
			if (roll < 3)
				it.frac = '0;
			else if (roll < 6)
				it.frac = '1;
		end else if (roll < 88) begin
			it.kind = KIND_WRITE;
			it.fit = rand_fitness();
			if (wheel > 0 && roll < 83)
				it.idx = IDX_W'($urandom_range(wheel - 1));
		end else if (roll < 96) begin
			it.kind = KIND_CLEAR;
		end else begin
			it.kind = KIND_UNUSED;
		end
		return it;
	endfunction

	task automatic offer(input req_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= it.kind;
		req_ch.entry_index <= it.idx;
		req_ch.fitness_value <= it.fit;
		req_ch.random_fraction <= it.frac;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic settle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_picks != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				hold_rsp = 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		req_item_t it;
		int        ph;
		int        sent;
		int        wheel;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_WRITE;
		req_ch.entry_index = '0;
		req_ch.fitness_value = '0;
		req_ch.random_fraction = '0;
		hold_rsp = 1'b0;
		send_idle = 28;
		recv_idle = 83;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// load every entry before anything reads the table
		for (int i = 0; i < MAX_ENTRIES_DEF; i++)
			offer(make_req(KIND_WRITE, IDX_W'(i), rand_fitness(), '0));

		for (ph = 0; ph < PHASES; ph++) begin
			settle();
			if (ph < 3) begin
				send_idle = 28;
				recv_idle = 83;
			end else if (ph < 7) begin
				send_idle = 83;
				recv_idle = 28;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			reg_write({REG_WITHOUT_REPL, 2'b00}, DATA_W'(PH_WO[ph]));
			reg_write({REG_POP_COUNT, 2'b00}, DATA_W'(PH_POP[ph]));

			case (ph)
				0: begin
					offer(make_req(KIND_WRITE, 8'd0, '1, '0));
					offer(make_req(KIND_WRITE, 8'd255, '0, '0));
					offer(make_req(KIND_WRITE, 8'd128, '0, '0));
					offer(make_req(KIND_SELECT, '0, '0, '0));
					offer(make_req(KIND_SELECT, '1, '1, '1));
					offer(make_req(KIND_SELECT, '0, '0, 16'h8000));
					offer(make_req(KIND_UNUSED, '1, '1, '1));
					offer(make_req(KIND_CLEAR, '0, '0, '0));
				end
				2: begin
					// run the two-entry wheel dry
					offer(make_req(KIND_CLEAR, '0, '0, '0));
					repeat (4) offer(make_req(KIND_SELECT, '0, '0, RND_W'($urandom)));
				end
				3: begin
					offer(make_req(KIND_WRITE, 8'd0, '0, '0));
					offer(make_req(KIND_SELECT, '0, '0, '0));
					offer(make_req(KIND_WRITE, 8'd0, '1, '0));
					offer(make_req(KIND_SELECT, '0, '0, '1));
				end
				4: begin
					offer(make_req(KIND_SELECT, '0, '0, '0));
					offer(make_req(KIND_SELECT, '0, '0, '1));
				end
				default: ;
			endcase

			if (ph == HOLD_PHASE)
				hold_rsp = 1'b1;
			wheel = (PH_POP[ph] > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : PH_POP[ph];
			sent = 0;
			while (sent < PH_ITEMS[ph]) begin
				it = rand_req(wheel);
				offer(it);
				if (it.kind != KIND_UNUSED)
					sent++;
			end
		end

		settle();
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/rws_pkg.sv
sv/rws_req_if.sv
sv/rws_rsp_if.sv
sv/rws_dp.sv
sv/rws_ctrl.sv
sv/roulette_wheel_selector.sv
sim/rws_pick_checker.sv
sim/roulette_wheel_selector_tb.sv
